// ----- rtl/page_cache_directory_lru_pinned_macros.svh -----
// assertion macros for the page cache directory
`ifndef PAGE_CACHE_DIRECTORY_LRU_PINNED_MACROS_SVH
`define PAGE_CACHE_DIRECTORY_LRU_PINNED_MACROS_SVH
// implication checked on every clock edge out of reset
`define PCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/pcd_pkg.sv -----
// shared types and codes of the page cache directory
`default_nettype none
package pcd_pkg;
    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_CREATE  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_UNDEF   = 2'd3;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RES   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic       REG_MAX     = 1'b0;
    localparam logic       REG_FIRST   = 1'b1;
    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic        load_needed;
        logic [5:0]  slot_index;
        logic [31:0] result_page_id;
        logic        evicted;
        logic [31:0] evicted_page_id;
    } t_result;
endpackage
`default_nettype wire

// ----- rtl/pcd_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/page_cache_directory_lru_pinned.sv -----
// page cache directory top level: lookup, lru victim choice and slot update
// Requests are taken only in idle. Every request first sweeps the slot
// memory once (one read a cycle) to find the page, the lowest free slot
// and the least recent unpinned slot, then waits until the output
// register is free and decides. A get hit, a fill or an eviction then
// runs a second sweep that rewrites the recency ranks one slot a cycle.
// The next request can be taken as soon as the response is valid, even
// while the response still waits, and a waiting response holds that
// request before its decision. Page numbers live in a slot ram, pin
// counts and ranks sit in a second ram holding one word per slot, and a
// valid bit per slot in flip-flops gives the reset state at once.
`default_nettype none
module page_cache_directory_lru_pinned
    import pcd_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int PIN_WIDTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // command[1:0], page_id[33:2], zero pad
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status, hit, load_needed, slot_index,
                                        // result_page_id, evicted, evicted_page_id
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [31:0]  i_cfg_data
);
    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int MW  = PIN_WIDTH + AW;
    localparam logic [PIN_WIDTH-1:0] PIN_MAX = {PIN_WIDTH{1'b1}};
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DEC = 3'd2,
        S_RANK = 3'd3, S_OUT = 3'd4, S_WAIT = 3'd5;

    localparam logic [1:0] MODE_PROMOTE = 2'd0, MODE_SWAP = 2'd1,
        MODE_INSERT = 2'd2, MODE_REMOVE = 2'd3;

    logic [2:0]     r_state, n_state;
    logic [6:0]     r_max;
    logic [31:0]    r_next_page;
    logic [CW-1:0]  r_vcount;
    logic [CAPACITY-1:0] r_valid;
    logic [1:0]     r_cmd;
    logic [31:0]    r_pid;
    logic [AW-1:0]  r_idx;
    logic           r_rd;
    logic [AW-1:0]  r_rd_idx;
    logic           r_found, r_free_ok, r_vic_ok;
    logic [AW-1:0]  r_found_s, r_free_s, r_vic_s, r_tgt;
    logic [AW-1:0]  r_found_rank, r_vic_rank;
    logic [31:0]    r_vic_page;
    logic [PIN_WIDTH-1:0] r_found_pins;
    // rank sweep mode
    logic [1:0]     r_mode;
    logic [AW-1:0]  r_thr;
    t_result        r_res;
    logic           r_ovalid;

    logic           page_we, meta_we;
    logic [AW-1:0]  page_wa, meta_wa, rd_a;
    logic [31:0]    page_wd, page_rd;
    logic [MW-1:0]  meta_wd, meta_rd;

    pcd_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_page (
        .i_clk, .i_we(page_we), .i_waddr(page_wa), .i_wdata(page_wd),
        .i_raddr(rd_a), .o_rdata(page_rd));
    pcd_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_meta (
        .i_clk, .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(rd_a), .o_rdata(meta_rd));

    logic [CW-1:0] limit;
    always_comb begin
        if (r_max == 7'd0 || {25'd0, r_max} > 32'(CAPACITY)) begin
            limit = CAP_C;
        end else begin
            limit = CW'(r_max);
        end
    end

    wire s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_res.evicted_page_id, r_res.evicted,
        r_res.result_page_id, r_res.slot_index, r_res.load_needed, r_res.hit,
        r_res.status};
    assign rd_a = r_idx;

    wire [PIN_WIDTH-1:0] rd_pins = meta_rd[MW-1:AW];
    wire [AW-1:0]        rd_rank = meta_rd[AW-1:0];
    wire                 rd_v    = r_valid[r_rd_idx];
    wire                 last    = (r_idx == AW'(CAPACITY - 1));
    wire                 fill_mode = (r_mode == MODE_SWAP) || (r_mode == MODE_INSERT);

    // decision after the scan
    logic          do_evict, still_full, do_fill;
    logic [CW-1:0] vc_after;
    always_comb begin
        do_evict   = (r_vcount >= limit) && r_vic_ok;
        vc_after   = do_evict ? r_vcount - CW'(1) : r_vcount;
        still_full = vc_after >= limit;
        do_fill    = !still_full && (r_free_ok || do_evict);
    end
    wire [AW-1:0] fill_s = (!r_free_ok || (do_evict && r_vic_s < r_free_s))
                           ? r_vic_s : r_free_s;

    always_comb begin
        page_we = 1'b0; page_wa = r_tgt; page_wd = r_pid;
        meta_we = 1'b0; meta_wa = r_rd_idx; meta_wd = meta_rd;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = S_SCAN;
            S_SCAN: if (r_rd && r_rd_idx == AW'(CAPACITY - 1)) n_state = S_WAIT;
            S_WAIT: if (!r_ovalid) n_state = S_DEC;
            S_DEC:  n_state = S_OUT;
            S_RANK: begin
                if (r_rd && (rd_v || (r_rd_idx == r_tgt && fill_mode))) begin
                    meta_we = 1'b1;
                    if (r_rd_idx == r_tgt && r_mode != MODE_REMOVE) begin
                        meta_wd = {(r_mode == MODE_PROMOTE) ?
                            ((r_found_pins == PIN_MAX) ? r_found_pins
                                : r_found_pins + PIN_WIDTH'(1))
                            : PIN_WIDTH'(1), AW'(0)};
                    end else if (r_mode == MODE_PROMOTE) begin
                        if (rd_rank < r_thr) meta_wd = {rd_pins, rd_rank + AW'(1)};
                    end else if (r_mode == MODE_REMOVE) begin
                        if (rd_rank > r_thr) meta_wd = {rd_pins, rd_rank - AW'(1)};
                    end else if (r_mode == MODE_SWAP && rd_rank > r_thr) begin
                        meta_wd = meta_rd;
                    end else begin
                        meta_wd = {rd_pins, rd_rank + AW'(1)};
                    end
                end
                if (r_rd && r_rd_idx == AW'(CAPACITY - 1)) n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_DEC && r_cmd == CMD_RELEASE && r_found) begin
            meta_we = 1'b1;
            meta_wa = r_found_s;
            meta_wd = {(r_found_pins == '0) ? r_found_pins
                : r_found_pins - PIN_WIDTH'(1), r_found_rank};
        end
        if (r_state == S_DEC && r_cmd != CMD_RELEASE && r_cmd != CMD_UNDEF &&
            ((r_cmd == CMD_GET && r_found) || do_fill || do_evict)) begin
            n_state = S_RANK;
        end
        if (r_state == S_RANK && r_rd_idx == r_tgt && fill_mode && r_rd) begin
            page_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max <= '0;
            r_next_page <= '0;
            r_vcount <= '0;
            r_valid <= '0;
            r_ovalid <= 1'b0;
            r_rd <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_MAX) begin
                    r_max <= i_cfg_data[6:0];
                end else begin
                    r_next_page <= i_cfg_data;
                end
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            r_rd <= 1'b0;
            r_rd_idx <= rd_a;
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_cmd <= s_axis_tdata[1:0];
                        r_pid <= s_axis_tdata[33:2];
                        r_idx <= '0;
                        r_found <= 1'b0; r_free_ok <= 1'b0; r_vic_ok <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (!last || !r_rd) begin
                        r_rd <= 1'b1;
                        if (!last) r_idx <= r_idx + AW'(1);
                    end
                    if (r_rd) begin
                        if (rd_v && page_rd == r_pid && !r_found) begin
                            r_found <= 1'b1; r_found_s <= r_rd_idx;
                            r_found_rank <= rd_rank; r_found_pins <= rd_pins;
                        end
                        if (!rd_v && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free_s <= r_rd_idx;
                        end
                        if (rd_v && rd_pins == '0 &&
                            (!r_vic_ok || rd_rank > r_vic_rank)) begin
                            r_vic_ok <= 1'b1; r_vic_s <= r_rd_idx;
                            r_vic_rank <= rd_rank; r_vic_page <= page_rd;
                        end
                    end
                end
                S_WAIT: begin
                end
                S_DEC: begin
                    r_res <= '0;
                    r_idx <= '0;
                    if (r_cmd == CMD_UNDEF) begin
                        r_res <= '0;
                    end else if (r_cmd == CMD_RELEASE) begin
                        if (r_found) begin
                            r_res.hit <= 1'b1;
                            r_res.slot_index <= 6'(r_found_s);
                            r_res.result_page_id <= r_pid;
                        end else begin
                            r_res.status <= ST_UNKNOWN;
                        end
                    end else if (r_cmd == CMD_GET && r_found) begin
                        r_res.hit <= 1'b1;
                        r_res.slot_index <= 6'(r_found_s);
                        r_res.result_page_id <= r_pid;
                        r_mode <= MODE_PROMOTE; r_thr <= r_found_rank;
                        r_tgt <= r_found_s;
                    end else begin
                        if (do_evict) begin
                            r_res.evicted <= 1'b1;
                            r_res.evicted_page_id <= r_vic_page;
                            r_valid[r_vic_s] <= 1'b0;
                            r_vcount <= vc_after;
                        end
                        if (!do_fill) begin
                            r_res.status <= ST_NO_RES;
                            if (do_evict) begin
                                // removal only: close the gap in the ranks
                                r_mode <= MODE_REMOVE; r_thr <= r_vic_rank;
                                r_tgt <= r_vic_s;
                            end
                        end else begin
                            r_mode <= do_evict ? MODE_SWAP : MODE_INSERT;
                            r_thr <= r_vic_rank;
                            r_tgt <= fill_s;
                            r_res.slot_index <= 6'(fill_s);
                            if (r_cmd == CMD_CREATE) begin
                                r_pid <= r_next_page;
                                r_res.result_page_id <= r_next_page;
                                r_next_page <= r_next_page + 32'd1;
                            end else begin
                                r_res.load_needed <= 1'b1;
                                r_res.result_page_id <= r_pid;
                            end
                        end
                    end
                end
                S_RANK: begin
                    if (!last || !r_rd) begin
                        r_rd <= 1'b1;
                        if (!last) r_idx <= r_idx + AW'(1);
                    end
                    if (r_rd && r_rd_idx == AW'(CAPACITY - 1) && fill_mode) begin
                        r_valid[r_tgt] <= 1'b1;
                        r_vcount <= r_vcount + CW'(1);
                    end
                end
                S_OUT: r_ovalid <= 1'b1;
                default: r_ovalid <= 1'b0;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/pcd_checker.sv -----
// port-level checker for the page cache directory, bound to the top level
`default_nettype none
`include "page_cache_directory_lru_pinned_macros.svh"
module pcd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [79:0] m_axis_tdata,
    input wire        o_cfg_ready
);
    `PCD_ASSERT_IMP(a_cfg_quiet, i_clk, i_rst_n, m_axis_tvalid, !o_cfg_ready)
    `PCD_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `PCD_ASSERT_IMP(a_no_status3, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[1:0] != 2'd3)
    `PCD_ASSERT_IMP(a_hit_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2],
        m_axis_tdata[1:0] == 2'd0 && !m_axis_tdata[3])
    `PCD_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !o_cfg_ready)
endmodule
bind page_cache_directory_lru_pinned pcd_checker u_pcd_checker (.*);
`default_nettype wire
